// ----- src/gpm_pkg.sv -----
// Package: widths, codes, reset values and control types for the gauge pressure mean block
`default_nettype none
package gpm_pkg;

  localparam int PRESS_W   = 48;
  localparam int SUM_W     = 52;
  localparam int CNT_W     = 4;
  localparam int STAT_W    = 8;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam int MAX_GAUGES_DEF = 10;

  localparam logic [PRESS_W-1:0] LOWER_RESET = PRESS_W'(64'd19900);
  localparam logic [PRESS_W-1:0] UPPER_RESET = PRESS_W'(64'd1010000000000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(1);

  // result status codes
  localparam logic [CODE_W-1:0] CODE_ALL_GOOD = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_SOME_POOR = CODE_W'(1);
  localparam logic [CODE_W-1:0] CODE_NONE_GOOD = CODE_W'(2);

  // highest gauge status that still marks a usable reading
  localparam logic [STAT_W-1:0] STAT_USABLE_MAX = STAT_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic acc;
    logic div_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/gpm_div.sv -----
// Restoring divider: sum by a 4-bit count, one quotient bit per cycle
`default_nettype none
module gpm_div
  import gpm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  logic [SUM_W-1:0]     dq_r, dq_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]       rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_r, dq_r[SUM_W-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    dq_nxt  = {dq_r[SUM_W-2:0], fits};
    rem_nxt = fits ? CNT_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[CNT_W-1:0];
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= DIV_CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = cnt_r == '0;
  assign quotient = dq_r;

endmodule
`default_nettype wire

// ----- src/gpm_dp.sv -----
// Datapath: limit registers, batch accumulators, divider and result registers
`default_nettype none
module gpm_dp
  import gpm_pkg::*;
#(
  parameter int MAX_GAUGES = MAX_GAUGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PRESS_W-1:0]   cfg_data,
  input  wire logic [PRESS_W-1:0]   in_pressure,
  input  wire logic [STAT_W-1:0]    in_gauge_status,
  output logic                      out_valid,
  output logic [CODE_W-1:0]         out_status_code,
  output logic [PRESS_W-1:0]        out_mean_pressure,
  output logic [PRESS_W-1:0]        out_max_pressure,
  output logic [PRESS_W-1:0]        out_min_pressure,
  output logic [CNT_W-1:0]          out_good_count,
  output logic [CNT_W-1:0]          out_total_count
);

  logic [PRESS_W-1:0] lower_r, upper_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   good_r, gauge_r;
  logic [PRESS_W-1:0] max_r, min_r;
  logic [PRESS_W-1:0] base_max, base_min;
  logic               counted, good;
  logic               div_done;
  logic [SUM_W-1:0]   quotient;
  logic               valid_r;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [PRESS_W-1:0] mean_r, maxo_r, mino_r;
  logic [CNT_W-1:0]   goodo_r, totalo_r;

  // the first item of a batch starts max and min from the limits
  always_comb begin
    base_max = (gauge_r == '0) ? lower_r : max_r;
    base_min = (gauge_r == '0) ? upper_r : min_r;
    counted  = gauge_r < CNT_W'(MAX_GAUGES);
    good     = counted && (in_gauge_status <= STAT_USABLE_MAX) &&
               (in_pressure >= lower_r) && (in_pressure <= upper_r);
    if (good_r == '0) begin
      code_nxt = CODE_NONE_GOOD;
    end else if (good_r == gauge_r) begin
      code_nxt = CODE_ALL_GOOD;
    end else begin
      code_nxt = CODE_SOME_POOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_LOWER) begin
        lower_r <= cfg_data;
      end else if (cfg_index == REG_UPPER) begin
        upper_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      good_r  <= '0;
      gauge_r <= '0;
    end else if (cmd.acc) begin
      gauge_r <= gauge_r + CNT_W'(counted);
      good_r  <= good_r + CNT_W'(good);
      if (good) begin
        sum_r <= sum_r + SUM_W'(in_pressure);
      end
    end else if (cmd.emit) begin
      sum_r   <= '0;
      good_r  <= '0;
      gauge_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      max_r <= (good && in_pressure > base_max) ? in_pressure : base_max;
      min_r <= (good && in_pressure < base_min) ? in_pressure : base_min;
    end
  end

  gpm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.div_load),
    .dividend (sum_r),
    .divisor  (good_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      code_r   <= code_nxt;
      mean_r   <= (good_r == '0) ? '0 : quotient[PRESS_W-1:0];
      maxo_r   <= max_r;
      mino_r   <= min_r;
      goodo_r  <= good_r;
      totalo_r <= gauge_r;
    end
  end

  assign out_valid         = valid_r;
  assign out_status_code   = code_r;
  assign out_mean_pressure = mean_r;
  assign out_max_pressure  = maxo_r;
  assign out_min_pressure  = mino_r;
  assign out_good_count    = goodo_r;
  assign out_total_count   = totalo_r;

endmodule
`default_nettype wire

// ----- src/gpm_ctrl.sv -----
// Controller: accepts items, sequences the end-of-batch division and result beat
`default_nettype none
module gpm_ctrl
  import gpm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_last,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        // emit the result and clear the batch once the quotient settles
        if (sts.div_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/gauge_pressure_mean_core.sv -----
// Top level: batch mean, max and min of vacuum gauge pressure readings
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | start / busy              | in_pressure, in_gauge_status, in_last
//  result   | out_valid (one-cycle)     | out_status_code, out_mean_pressure, ...
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  An item that is not last is accumulated; busy stays low and the next item
//  may follow at once. For a last item the mean is formed by a divider that
//  yields one quotient bit per cycle; busy is high until the result beat, and
//  the next item may be taken in the cycle that beat is shown.
//  Reset is synchronous: limits return to their defaults and the batch clears.
//  The receiver cannot stall; cfg_ready is always high.
`default_nettype none
module gauge_pressure_mean_core
  import gpm_pkg::*;
#(
  parameter int MAX_GAUGES = MAX_GAUGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PRESS_W-1:0]   in_pressure,
  input  wire logic [STAT_W-1:0]    in_gauge_status,
  input  wire logic                 in_last,
  output logic                      out_valid,
  output logic [CODE_W-1:0]         out_status_code,
  output logic [PRESS_W-1:0]        out_mean_pressure,
  output logic [PRESS_W-1:0]        out_max_pressure,
  output logic [PRESS_W-1:0]        out_min_pressure,
  output logic [CNT_W-1:0]          out_good_count,
  output logic [CNT_W-1:0]          out_total_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PRESS_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gpm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  gpm_dp #(
    .MAX_GAUGES (MAX_GAUGES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_pressure       (in_pressure),
    .in_gauge_status   (in_gauge_status),
    .out_valid         (out_valid),
    .out_status_code   (out_status_code),
    .out_mean_pressure (out_mean_pressure),
    .out_max_pressure  (out_max_pressure),
    .out_min_pressure  (out_min_pressure),
    .out_good_count    (out_good_count),
    .out_total_count   (out_total_count)
  );

endmodule
`default_nettype wire
